>>> hw/rtl/bpa_pkg.sv
// shared constants and widths of the bitmap page allocator
package bpa_pkg;

  localparam int NUM_BLOCKS_DEF = 4096;   // default number of managed blocks
  localparam int WORD_BITS      = 64;     // bitmap bits held in one ram row
  localparam int OFF_W          = 6;      // bit offset inside a ram row
  localparam int MAP_W          = 10;     // map_bytes register width
  localparam int BLK_W          = 12;     // block_index / start_block width
  localparam int CNT_W          = 13;     // count width
  localparam int IN_DATA_W      = 32;     // block_index + count, byte padded
  localparam int OUT_DATA_W     = 16;     // start_block, byte padded

  localparam logic [MAP_W-1:0] MAP_BYTES_RESET = 10'd512;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

>>> hw/rtl/bpa_ram.sv
// generic simple dual-port ram with registered read
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bpa_row_scan.sv
// first-fit search of one bitmap row, with the free run carried in from earlier rows
module bpa_row_scan (
  input  logic [bpa_pkg::WORD_BITS-1:0] free_bits,   // 1 = block free and in range
  input  logic [bpa_pkg::CNT_W-1:0]     carry,       // free blocks ending the row before
  input  logic [bpa_pkg::CNT_W-1:0]     need,        // requested run length, nonzero
  output logic                          hit,
  output logic                          hit_prefix,  // run starts in an earlier row
  output logic [bpa_pkg::OFF_W-1:0]     hit_pos,
  output logic [bpa_pkg::CNT_W-1:0]     carry_next,
  output logic                          tail_restart,
  output logic [bpa_pkg::OFF_W-1:0]     tail_pos
);

  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int OW = bpa_pkg::OFF_W;
  localparam int CW = bpa_pkg::CNT_W;

  logic          any_used;
  logic [OW-1:0] first_used;
  logic [OW-1:0] last_used;
  logic [OW:0]   head_free;
  logic          prefix_ok;
  logic [WB-1:0] win [OW+1];   // win[s][i]: 2**s free bits from i
  logic [WB-1:0] acc;
  logic [OW:0]   need_lo;
  logic [OW:0]   low;
  logic          win_ok;

  // first and last used bit of the row
  always_comb begin
    any_used   = 1'b0;
    first_used = '0;
    last_used  = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (!free_bits[j]) begin
        first_used = OW'(j);
      end
    end
    for (int j = 0; j < WB; j++) begin
      if (!free_bits[j]) begin
        any_used  = 1'b1;
        last_used = OW'(j);
      end
    end
  end

  assign head_free = any_used ? {1'b0, first_used} : (OW + 1)'(WB);
  assign prefix_ok = (carry != '0) &&
                     (({1'b0, carry} + (CW + 1)'(head_free)) >= {1'b0, need});

  // window of need free bits starting inside the row, built from power-of-two windows
  assign need_lo = need[OW:0];
  assign win_ok  = (need <= CW'(WB));

  always_comb begin
    win[0] = free_bits;
    for (int s = 1; s <= OW; s++) begin
      win[s] = win[s-1] & (win[s-1] >> (1 << (s - 1)));
    end
    acc = '1;
    low = '0;
    for (int s = 0; s <= OW; s++) begin
      low = need_lo & ((OW + 1)'(1 << s) - 1'b1);
      if (need_lo[s]) begin
        acc = acc & (win[s] >> low);
      end
    end
    hit_pos = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (acc[j]) begin
        hit_pos = OW'(j);
      end
    end
  end

  assign hit_prefix = prefix_ok;
  assign hit        = prefix_ok || (win_ok && (acc != '0));

  // free run left open at the top of the row
  assign carry_next   = any_used ? CW'(OW'(WB - 1) - last_used) : CW'(carry + CW'(WB));
  assign tail_restart = any_used ? (last_used != OW'(WB - 1)) : (carry == '0);
  assign tail_pos     = any_used ? OW'(last_used + 1'b1) : '0;

endmodule

>>> hw/rtl/bitmap_page_allocator.sv
// bitmap page allocator top level: sequencer, bitmap ram and row scan unit
//
// usage
//   s_* channel takes one request per transfer: s_tuser is the opcode (0 allocate,
//   1 free), s_tdata holds block_index and count. m_* channel returns exactly one
//   result per request: m_tuser is ok, m_tdata holds start_block (0 on failure/free).
//   cfg_* channel writes map_bytes; allocation scans 8*map_bytes blocks, capped at
//   NUM_BLOCKS. cfg_ready is always high; write it only while the block is idle.
// timing
//   the bitmap sits in a ram of 64-bit rows, one row read per cycle. allocate scans
//   rows up to the row holding the found run or the last scanned row, then marks the
//   rows of the run; a failed allocate only scans; free marks the rows it touches.
//   zero-count, empty-range and out-of-range requests go straight to the done state.
//   the 64-bit row scan unit and the single ram read port set this scan rate.
//   one request is in work at a time; s_tready is high only while idle.
// reset
//   every block reads as used after reset: per-row valid flops clear at once and an
//   unwritten row reads as all ones, so there is no clearing sweep.
// stall
//   a result sits in the output register while m_tready is low; a new request is
//   still taken, and its own result waits until the register frees up.
module bitmap_page_allocator #(
  parameter int NUM_BLOCKS = bpa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request: s_tdata = block_index[11:0], count[24:12], zero pad; s_tuser = opcode
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bpa_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tuser,
  // result: m_tdata = start_block[11:0], zero pad; m_tuser = ok
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tuser,
  // map_bytes write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpa_pkg::MAP_W-1:0]        cfg_data
);

  localparam int WB    = bpa_pkg::WORD_BITS;
  localparam int OW    = bpa_pkg::OFF_W;
  localparam int CW    = bpa_pkg::CNT_W;
  localparam int BW    = bpa_pkg::BLK_W;
  localparam int ODW   = bpa_pkg::OUT_DATA_W;
  localparam int ROWS  = (NUM_BLOCKS + WB - 1) / WB;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW    = $clog2(NUM_BLOCKS + 1);
  localparam int PW    = (LW > 14) ? LW : 14;   // block positions and run ends

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_SCAN       = 5'b00010,
    ST_MARK_START = 5'b00100,
    ST_MARK       = 5'b01000,
    ST_DONE       = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [bpa_pkg::MAP_W-1:0] map_bytes;

  // request registers
  logic          op;
  logic [CW-1:0] need;
  logic [PW-1:0] mark_s;
  logic [PW-1:0] mark_e;
  logic          res_ok;
  logic [BW-1:0] res_blk;

  // scan and mark position
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    carry;
  logic [PW-1:0]    run_first;

  // bitmap storage
  logic [ROWS-1:0]  row_valid;
  logic             rvalid_q;
  logic [ROW_W-1:0] raddr;
  logic             we;
  logic [WB-1:0]    wdata;
  logic [WB-1:0]    rdata;
  logic [WB-1:0]    base_word;

  // derived values
  logic [PW-1:0]    limit_raw;
  logic [PW-1:0]    limit;
  logic [ROW_W-1:0] last_scan_row;
  logic [PW-1:0]    row_base;
  logic [PW-1:0]    scan_rem;
  logic [PW-1:0]    mark_rel;
  logic [OW-1:0]    mark_lo;
  logic [ROW_W-1:0] mark_first_row;
  logic [ROW_W-1:0] mark_last_row;
  logic [WB-1:0]    free_bits;
  logic [WB-1:0]    mark_mask;

  // request decode
  logic           accept;
  logic           in_op;
  logic [BW-1:0]  in_blk;
  logic [CW-1:0]  in_cnt;
  logic [PW-1:0]  free_e_raw;
  logic [PW-1:0]  free_e;
  logic           free_none;

  // row scan unit
  logic          hit;
  logic          hit_prefix;
  logic [OW-1:0] hit_pos;
  logic [CW-1:0] carry_next;
  logic          tail_restart;
  logic [OW-1:0] tail_pos;
  logic [PW-1:0] hit_start;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  assign in_op  = s_tuser;
  assign in_blk = s_tdata[BW-1:0];
  assign in_cnt = s_tdata[BW+CW-1:BW];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_bytes <= bpa_pkg::MAP_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      map_bytes <= cfg_data;
    end
  end

  // scan limit: 8*map_bytes, capped at the bitmap size
  assign limit_raw     = PW'({map_bytes, 3'b000});
  assign limit         = (limit_raw > PW'(NUM_BLOCKS)) ? PW'(NUM_BLOCKS) : limit_raw;
  assign last_scan_row = ROW_W'((limit - 1'b1) >> OW);

  // free range, clipped at the end of the bitmap
  assign free_e_raw = PW'(in_blk) + PW'(in_cnt);
  assign free_e     = (free_e_raw > PW'(NUM_BLOCKS)) ? PW'(NUM_BLOCKS) : free_e_raw;
  assign free_none  = (in_cnt == '0) || (PW'(in_blk) >= PW'(NUM_BLOCKS));

  // the row the ram data belongs to in scan and mark states
  assign row_base  = PW'({row, OW'(0)});
  assign base_word = rvalid_q ? rdata : '1;

  assign scan_rem = limit - row_base;
  assign mark_rel = mark_e - row_base;

  assign mark_first_row = ROW_W'(mark_s >> OW);
  assign mark_last_row  = ROW_W'((mark_e - 1'b1) >> OW);
  assign mark_lo        = (row == mark_first_row) ? mark_s[OW-1:0] : '0;

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      free_bits[j] = !base_word[j] && (PW'(j) < scan_rem);
      mark_mask[j] = (OW'(j) >= mark_lo) && (PW'(j) < mark_rel);
    end
  end

  bpa_row_scan u_scan (
    .free_bits    (free_bits),
    .carry        (carry),
    .need         (need),
    .hit          (hit),
    .hit_prefix   (hit_prefix),
    .hit_pos      (hit_pos),
    .carry_next   (carry_next),
    .tail_restart (tail_restart),
    .tail_pos     (tail_pos)
  );

  assign hit_start = hit_prefix ? run_first : (row_base + PW'(hit_pos));

  // ram read address: next row is fetched while the current one is processed
  always_comb begin
    raddr = '0;
    unique case (state)
      ST_IDLE:       raddr = '0;
      ST_SCAN:       raddr = (row == last_scan_row) ? row : ROW_W'(row + 1'b1);
      ST_MARK_START: raddr = mark_first_row;
      ST_MARK:       raddr = (row == mark_last_row) ? row : ROW_W'(row + 1'b1);
      ST_DONE:       raddr = '0;
      default:       raddr = '0;
    endcase
  end

  // read-modify-write of one row per cycle while marking
  assign we    = (state == ST_MARK);
  assign wdata = (op == bpa_pkg::OP_ALLOC) ? (base_word | mark_mask)
                                           : (base_word & ~mark_mask);

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (row),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // unwritten rows read as all used
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= row_valid[raddr];
      if (we) begin
        row_valid[row] <= 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == bpa_pkg::OP_FREE) begin
            state_next = free_none ? ST_DONE : ST_MARK_START;
          end else begin
            state_next = ((in_cnt == '0) || (limit == '0)) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_MARK_START;
        end else if (row == last_scan_row) begin
          state_next = ST_DONE;
        end
      end
      ST_MARK_START: state_next = ST_MARK;
      ST_MARK: begin
        if (row == mark_last_row) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op        <= in_op;
          need      <= in_cnt;
          row       <= '0;
          carry     <= '0;
          run_first <= '0;
          mark_s    <= PW'(in_blk);
          mark_e    <= free_e;
          res_ok    <= (in_op == bpa_pkg::OP_FREE);
          res_blk   <= '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mark_s  <= hit_start;
          mark_e  <= hit_start + PW'(need);
          res_ok  <= 1'b1;
          res_blk <= hit_start[BW-1:0];
        end else begin
          row   <= ROW_W'(row + 1'b1);
          carry <= carry_next;
          if (tail_restart) begin
            run_first <= row_base + PW'(tail_pos);
          end
        end
      end
      ST_MARK_START: row <= mark_first_row;
      ST_MARK: begin
        if (row != mark_last_row) begin
          row <= ROW_W'(row + 1'b1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register: loaded from the done state, held while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= ODW'(res_blk);
      m_tuser <= res_ok;
    end
  end

endmodule
